// ----- sv/bptc_pkg.sv -----
package bptc_pkg;

   // Datapath width of the pressure math
   localparam int unsigned WideW = 64;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_TEMP_CAL   = 2'd0,
      CSR_PRESS_LOW  = 2'd1,
      CSR_PRESS_HIGH = 2'd2,
      CSR_PRESS_NINE = 2'd3
   } csr_index_type;

   // Compensation constants
   localparam logic [63:0] FineOffset  = 64'd128000;
   localparam logic [63:0] PressFull   = 64'd1048576;
   localparam logic [63:0] PressScale  = 64'd3125;
   localparam logic [63:0] CalBias     = 64'h0000_8000_0000_0000;
   localparam logic [31:0] RoundCenti  = 32'd128;

   // Per-item data that rides along the whole pipeline
   typedef struct packed {
      logic [19:0] raw_pressure;
      logic [31:0] temperature_centi;
      logic [31:0] fine_temperature;
      logic        pressure_invalid;
   } side_type;

endpackage

// ----- sv/bptc_mul64.sv -----
module bptc_mul64 (
   input  logic                       clock,
   input  logic                       en,
   input  logic [bptc_pkg::WideW-1:0] a,
   input  logic [bptc_pkg::WideW-1:0] b,
   output logic [bptc_pkg::WideW-1:0] p
);
   import bptc_pkg::*;

   localparam int unsigned HalfW = WideW / 2;

   logic [WideW-1:0] low_ff, low_in;
   logic [HalfW-1:0] mid_ff, mid_in;
   logic [WideW-1:0] p_ff, p_in;

   // Split into 32x32 partial products; only the low half of each cross term matters
   always_comb begin
      low_in = WideW'(a[HalfW-1:0]) * WideW'(b[HalfW-1:0]);
      mid_in = a[WideW-1:HalfW] * b[HalfW-1:0] + a[HalfW-1:0] * b[WideW-1:HalfW];
      p_in   = low_ff + {mid_ff, {HalfW{1'b0}}};
   end

   // Advance both stages when the pipeline moves
   always_ff @(posedge clock) begin
      if (en) begin
         low_ff <= low_in;
         mid_ff <= mid_in;
         p_ff   <= p_in;
      end
   end

   assign p = p_ff;

endmodule

// ----- sv/bptc_div.sv -----
module bptc_div (
   input  logic                       clock,
   input  logic                       en,
   input  logic [bptc_pkg::WideW-1:0] dividend,
   input  logic [bptc_pkg::WideW-1:0] divisor,
   output logic [bptc_pkg::WideW-1:0] quotient
);
   import bptc_pkg::*;

   // One quotient bit per stage, restoring, unsigned
   logic [WideW-1:0] rem_ff [WideW];
   logic [WideW-1:0] nq_ff  [WideW];
   logic [WideW-1:0] dv_ff  [WideW];

   for (genvar k = 0; k < WideW; k++) begin : g_stage
      logic [WideW-1:0] rem_prev, nq_prev, dv_prev;
      logic [WideW:0]   shifted, diff;
      logic             ge;

      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign nq_prev  = dividend;
         assign dv_prev  = divisor;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign nq_prev  = nq_ff[k-1];
         assign dv_prev  = dv_ff[k-1];
      end

      // Shift in the next dividend bit, subtract when it fits
      always_comb begin
         shifted = {rem_prev, nq_prev[WideW-1]};
         diff    = shifted - {1'b0, dv_prev};
         ge      = ~diff[WideW];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? diff[WideW-1:0] : shifted[WideW-1:0];
            nq_ff[k]  <= {nq_prev[WideW-2:0], ge};
            dv_ff[k]  <= dv_prev;
         end
      end
   end

   assign quotient = nq_ff[WideW-1];

endmodule

// ----- sv/barometric_temp_pressure_compensation_unit.sv -----
// Barometric temperature and pressure compensation.
// Input channel req_*: one raw 20-bit temperature and pressure pair per transfer.
// Result channel rsp_*: temperature in 0.01 degC, fine temperature, pressure in
// Pa as unsigned Q24.8, and an invalid flag set when the pressure divisor is zero
// (pressure then reads 0).
// Configuration channel csr_*: index 0 temperature calibration words, 1 and 2 the
// low and high pressure words, 3 the ninth pressure coefficient (low 16 bits of
// csr_wdata). Write only while the pipeline is empty; csr_ready is always high.
// One item is accepted every cycle unless the receiver stalls. The 64-stage
// bit-per-cycle divider sets most of the latency; the rest is the temperature
// math and 64-bit multiplies built from 32x32 partial products, two stages each.
// The whole pipeline advances together; when the receiver stalls with a result
// waiting, every stage holds and req_ready drops, so nothing is lost or repeated.
// Synchronous reset empties the pipeline and clears all calibration registers.
module barometric_temp_pressure_compensation_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [19:0] req_raw_temperature,
   input  logic [19:0] req_raw_pressure,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_temperature_centi,
   output logic signed [31:0] rsp_fine_temperature,
   output logic [31:0] rsp_pressure_q24_8,
   output logic        rsp_pressure_invalid,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  bptc_pkg::csr_index_type csr_index,
   input  logic [63:0] csr_wdata
);
   import bptc_pkg::*;

   localparam int unsigned Depth   = 83;
   localparam int unsigned StFine  = 4;
   localparam int unsigned StM3In  = 9;
   localparam int unsigned StInv   = 12;

   // Calibration registers
   logic [47:0] tcal_ff;
   logic [63:0] pcal_lo_ff, pcal_hi_ff;
   logic [15:0] pcal_9_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tcal_ff    <= '0;
         pcal_lo_ff <= '0;
         pcal_hi_ff <= '0;
         pcal_9_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TEMP_CAL:   tcal_ff    <= csr_wdata[47:0];
            CSR_PRESS_LOW:  pcal_lo_ff <= csr_wdata;
            CSR_PRESS_HIGH: pcal_hi_ff <= csr_wdata;
            CSR_PRESS_NINE: pcal_9_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Coefficients, sign extended except t1 and p1, which are unsigned
   logic [31:0] t1, t2, t3;
   logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
   always_comb begin
      t1 = {16'b0, tcal_ff[15:0]};
      t2 = {{16{tcal_ff[31]}}, tcal_ff[31:16]};
      t3 = {{16{tcal_ff[47]}}, tcal_ff[47:32]};
      p1 = {48'b0, pcal_lo_ff[15:0]};
      p2 = {{48{pcal_lo_ff[31]}}, pcal_lo_ff[31:16]};
      p3 = {{48{pcal_lo_ff[47]}}, pcal_lo_ff[47:32]};
      p4 = {{48{pcal_lo_ff[63]}}, pcal_lo_ff[63:48]};
      p5 = {{48{pcal_hi_ff[15]}}, pcal_hi_ff[15:0]};
      p6 = {{48{pcal_hi_ff[31]}}, pcal_hi_ff[31:16]};
      p7 = {{48{pcal_hi_ff[47]}}, pcal_hi_ff[47:32]};
      p8 = {{48{pcal_hi_ff[63]}}, pcal_hi_ff[63:48]};
      p9 = {{48{pcal_9_ff[15]}}, pcal_9_ff};
   end

   // Global advance: move when the output slot is free or being taken
   logic en;
   assign en        = rsp_ready | ~rsp_valid;
   assign req_ready = en;

   // Valid bits and side data travel with every stage
   logic     vld_ff [Depth];
   side_type side_ff [Depth];
   side_type side_in [Depth];

   logic [31:0] fine_ff, tc_in;
   logic        zero_in;

   always_comb begin
      side_in[0] = '{raw_pressure: req_raw_pressure, temperature_centi: '0,
                     fine_temperature: '0, pressure_invalid: 1'b0};
      for (int k = 1; k < Depth; k++) begin
         side_in[k] = side_ff[k-1];
         if (k == StFine) begin
            side_in[k].temperature_centi = tc_in;
            side_in[k].fine_temperature  = fine_ff;
         end
         if (k == StInv) begin
            side_in[k].pressure_invalid = zero_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < Depth; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k < Depth; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < Depth; k++) side_ff[k] <= side_in[k];
      end
   end

   // Temperature path, 32-bit wrapping math
   logic [31:0] x1_ff, d_ff, a_ff, dd_ff, as_ff, e_ff;
   logic [63:0] v1_ff, v1_in;
   logic [31:0] fine_in;

   always_comb begin
      fine_in = as_ff + 32'($signed(e_ff) >>> 14);
      tc_in   = 32'($signed((fine_ff << 2) + fine_ff + RoundCenti) >>> 8);
      v1_in   = {{32{fine_ff[31]}}, fine_ff} - FineOffset;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff   <= {15'b0, req_raw_temperature[19:3]} - {t1[30:0], 1'b0};
         d_ff    <= {16'b0, req_raw_temperature[19:4]} - t1;
         a_ff    <= x1_ff * t2;
         dd_ff   <= d_ff * d_ff;
         as_ff   <= 32'($signed(a_ff) >>> 11);
         e_ff    <= 32'($signed(dd_ff) >>> 12) * t3;
         fine_ff <= fine_in;
         v1_ff   <= v1_in;
      end
   end

   // Pressure terms: v1 squared, then the products of the second group
   logic [63:0] vv, v1d1_ff, v1d2_ff;
   logic [63:0] v2a, vvp3, v1p5, v1p2;

   always_ff @(posedge clock) begin
      if (en) begin
         v1d1_ff <= v1_ff;
         v1d2_ff <= v1d1_ff;
      end
   end

   bptc_mul64 u_mul_vv   (.clock, .en, .a(v1_ff),   .b(v1_ff), .p(vv));
   bptc_mul64 u_mul_v2a  (.clock, .en, .a(vv),      .b(p6),    .p(v2a));
   bptc_mul64 u_mul_vvp3 (.clock, .en, .a(vv),      .b(p3),    .p(vvp3));
   bptc_mul64 u_mul_v1p5 (.clock, .en, .a(v1d2_ff), .b(p5),    .p(v1p5));
   bptc_mul64 u_mul_v1p2 (.clock, .en, .a(v1d2_ff), .b(p2),    .p(v1p2));

   // Combine into v2 and the divisor precursor
   logic [63:0] v2_ff, v1b_ff, num_a, den_a;

   always_ff @(posedge clock) begin
      if (en) begin
         v2_ff  <= v2a + (v1p5 << 17) + (p4 << 35);
         v1b_ff <= 64'($signed(vvp3) >>> 8) + (v1p2 << 12);
      end
   end

   always_comb begin
      num_a = ((PressFull - {44'b0, side_ff[StM3In].raw_pressure}) << 31) - v2_ff;
      den_a = CalBias + v1b_ff;
   end

   logic [63:0] numq, denq;
   bptc_mul64 u_mul_num (.clock, .en, .a(num_a), .b(PressScale), .p(numq));
   bptc_mul64 u_mul_den (.clock, .en, .a(den_a), .b(p1),         .p(denq));

   // Divisor, signs and magnitudes
   logic [63:0] v1f, mag_n_ff, mag_d_ff;
   logic        neg_ff [StInv:StInv + WideW];

   always_comb begin
      v1f     = 64'($signed(denq) >>> 33);
      zero_in = (v1f == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_n_ff  <= numq[63] ? -numq : numq;
         mag_d_ff  <= v1f[63] ? -v1f : v1f;
         neg_ff[StInv] <= numq[63] ^ v1f[63];
         for (int k = StInv + 1; k <= StInv + WideW; k++) neg_ff[k] <= neg_ff[k-1];
      end
   end

   logic [63:0] quo;
   bptc_div u_div (.clock, .en, .dividend(mag_n_ff), .divisor(mag_d_ff), .quotient(quo));

   // Signed quotient, then the correction terms
   logic [63:0] p_ff, pd1_ff, pd2_ff, pd3_ff, pd4_ff, ps_a, ps_b;
   logic [63:0] t9, w1m, w2m;

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff   <= neg_ff[StInv + WideW] ? -quo : quo;
         pd1_ff <= p_ff;
         pd2_ff <= pd1_ff;
         pd3_ff <= pd2_ff;
         pd4_ff <= pd3_ff;
      end
   end

   always_comb begin
      ps_a = 64'($signed(p_ff) >>> 13);
      ps_b = 64'($signed(pd2_ff) >>> 13);
   end

   bptc_mul64 u_mul_t9 (.clock, .en, .a(p9),  .b(ps_a),   .p(t9));
   bptc_mul64 u_mul_w1 (.clock, .en, .a(t9),  .b(ps_b),   .p(w1m));
   bptc_mul64 u_mul_w2 (.clock, .en, .a(p8),  .b(pd2_ff), .p(w2m));

   // Final sum into the output register
   logic [63:0] sum, res;
   logic [31:0] press_ff;

   always_comb begin
      sum = pd4_ff + 64'($signed(w1m) >>> 25) + 64'($signed(w2m) >>> 19);
      res = 64'($signed(sum) >>> 8) + (p7 << 4);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         press_ff <= side_ff[Depth-2].pressure_invalid ? 32'd0 : res[31:0];
      end
   end

   assign rsp_valid             = vld_ff[Depth-1];
   assign rsp_temperature_centi = side_ff[Depth-1].temperature_centi;
   assign rsp_fine_temperature  = side_ff[Depth-1].fine_temperature;
   assign rsp_pressure_q24_8    = press_ff;
   assign rsp_pressure_invalid  = side_ff[Depth-1].pressure_invalid;

endmodule

// ----- tb/bptc_checker.sv -----
module bptc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [19:0] req_raw_temperature,
   input  logic [19:0] req_raw_pressure,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_temperature_centi,
   input  logic [31:0] rsp_fine_temperature,
   input  logic [31:0] rsp_pressure_q24_8,
   input  logic        rsp_pressure_invalid,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  bptc_pkg::csr_index_type csr_index,
   input  logic [63:0] csr_wdata,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import bptc_pkg::*;

   typedef struct packed {
      logic [31:0] temperature_centi;
      logic [31:0] fine_temperature;
      logic [31:0] pressure_q24_8;
      logic        pressure_invalid;
   } reading_type;

   logic [47:0] temp_cal;
   logic [63:0] press_low;
   logic [63:0] press_high;
   logic [15:0] press_ninth;
   reading_type compensated_q[$];

   function automatic logic signed [63:0] slice16(logic [63:0] v, int pos);
      logic signed [15:0] s;
      s = v[pos +: 16];
      return 64'(s);
   endfunction

   // Datasheet compensation: 32-bit temperature, 64-bit pressure, C wraparound
   function automatic reading_type compensate(logic [19:0] adc_t, logic [19:0] adc_p);
      reading_type r;
      logic signed [31:0] t1, t2, t3, a, d, b, fine;
      logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic signed [63:0] v1, v2, p, ps, w1, w2, num;
      logic [63:0] ma, mb, q;
      t1 = {16'd0, temp_cal[15:0]};
      t2 = 32'(slice16({16'd0, temp_cal}, 16));
      t3 = 32'(slice16({16'd0, temp_cal}, 32));
      a = (({12'd0, adc_t} >>> 3) - (t1 <<< 1)) * t2;
      a = a >>> 11;
      d = ({12'd0, adc_t} >>> 4) - t1;
      b = (((d * d) >>> 12) * t3) >>> 14;
      fine = a + b;
      r.fine_temperature = fine;
      r.temperature_centi = (fine * 32'sd5 + 32'sd128) >>> 8;
      p1 = {48'd0, press_low[15:0]};
      p2 = slice16(press_low, 16);
      p3 = slice16(press_low, 32);
      p4 = slice16(press_low, 48);
      p5 = slice16(press_high, 0);
      p6 = slice16(press_high, 16);
      p7 = slice16(press_high, 32);
      p8 = slice16(press_high, 48);
      p9 = slice16({48'd0, press_ninth}, 0);
      v1 = 64'(fine) - 64'sd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) <<< 17);
      v2 = v2 + (p4 <<< 35);
      v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
      v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
      r.pressure_q24_8 = '0;
      r.pressure_invalid = (v1 == 0);
      if (v1 != 0) begin
         p = 64'sd1048576 - {44'd0, adc_p};
         num = ((p <<< 31) - v2) * 64'sd3125;
         ma = num[63] ? -num : num;
         mb = v1[63] ? -v1 : v1;
         q = ma / mb;
         p = (num[63] != v1[63]) ? -q : q;
         ps = p >>> 13;
         w1 = (p9 * ps * ps) >>> 25;
         w2 = (p8 * p) >>> 19;
         p = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
         r.pressure_q24_8 = p[31:0];
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      reading_type got, want;
      if (reset) begin
         temp_cal <= '0;
         press_low <= '0;
         press_high <= '0;
         press_ninth <= '0;
         compensated_q.delete();
         fail_count <= 0;
      end else begin
         // Track register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TEMP_CAL:   temp_cal <= csr_wdata[47:0];
               CSR_PRESS_LOW:  press_low <= csr_wdata;
               CSR_PRESS_HIGH: press_high <= csr_wdata;
               CSR_PRESS_NINE: press_ninth <= csr_wdata[15:0];
               default: ;
            endcase
         end
         // Predict on each input transfer
         if (req_valid && req_ready)
            compensated_q.push_back(compensate(req_raw_temperature, req_raw_pressure));
         // Compare each result transfer with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            got.temperature_centi = rsp_temperature_centi;
            got.fine_temperature = rsp_fine_temperature;
            got.pressure_q24_8 = rsp_pressure_q24_8;
            got.pressure_invalid = rsp_pressure_invalid;
            if (compensated_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected result transfer");
               fail_count <= fail_count + 1;
            end else begin
               want = compensated_q.pop_front();
               if (got != want) begin
                  if (fail_count < 10)
                     $display("mismatch exp tc=%0d ft=%0d p=%h inv=%b got tc=%0d ft=%0d p=%h inv=%b",
                        $signed(want.temperature_centi), $signed(want.fine_temperature),
                        want.pressure_q24_8, want.pressure_invalid,
                        $signed(got.temperature_centi), $signed(got.fine_temperature),
                        got.pressure_q24_8, got.pressure_invalid);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

   assign pending_count = compensated_q.size();
endmodule

// ----- tb/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import bptc_pkg::*;

   localparam int StallLimit = 5000;
   localparam int Latency = 83;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [19:0] req_raw_temperature = '0;
   logic [19:0] req_raw_pressure = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [31:0] rsp_temperature_centi;
   logic signed [31:0] rsp_fine_temperature;
   logic [31:0] rsp_pressure_q24_8;
   logic rsp_pressure_invalid;
   logic csr_valid = 0;
   logic csr_ready;
   csr_index_type csr_index = CSR_TEMP_CAL;
   logic [63:0] csr_wdata = '0;
   int fail_count, pending_count;
   int idle_cycles = 0;
   bit calm = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   barometric_temp_pressure_compensation_unit dut (.*);
   bptc_checker checker_i (.*);

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StallLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Receiver stalls at random
   always @(negedge clock)
      rsp_ready <= calm || ($urandom_range(99) >= 10);

   // Write one register, then leave the channel idle before returning
   task automatic write_reg(csr_index_type idx, logic [63:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   // Hold valid across items; drop it only while idling
   task automatic send_reading(logic [19:0] t, logic [19:0] p);
      while (!calm && $urandom_range(99) < 10) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_raw_temperature <= t;
      req_raw_pressure <= p;
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (Latency + 10) @(negedge clock);
   endtask

   // Typical datasheet calibration
   task automatic load_typical();
      write_reg(CSR_TEMP_CAL, {16'hFC18, 16'd26435, 16'd27504});
      write_reg(CSR_PRESS_LOW, {16'd2855, 16'd8192 - 16'd16, 16'hD6D0, 16'd36477});
      write_reg(CSR_PRESS_HIGH, {16'hFF00 + 16'd0, 16'd15500, 16'hFFF9, 16'd140});
      write_reg(CSR_PRESS_NINE, 64'hFFFF_FFFF_FFFF_1770);
   endtask

   task automatic load_random();
      write_reg(CSR_TEMP_CAL, {$urandom, $urandom});
      write_reg(CSR_PRESS_LOW, {$urandom, $urandom});
      write_reg(CSR_PRESS_HIGH, {$urandom, $urandom});
      write_reg(CSR_PRESS_NINE, {$urandom, $urandom});
   endtask

   task automatic random_burst(int n, bit plausible);
      for (int i = 0; i < n; i++) begin
         if (plausible && $urandom_range(9) != 0)
            send_reading(20'($urandom_range(400000, 600000)),
                         20'($urandom_range(250000, 450000)));
         else
            send_reading(20'($urandom), 20'($urandom));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Zero calibration: divisor zero, pressure invalid
      send_reading('0, '0);
      send_reading(20'hFFFFF, 20'hFFFFF);
      drain();

      // Typical setup with extreme and mid readings
      load_typical();
      send_reading('0, '0);
      send_reading(20'hFFFFF, 20'hFFFFF);
      send_reading('0, 20'hFFFFF);
      send_reading(20'hFFFFF, '0);
      send_reading(20'd519888, 20'd415148);
      send_reading(20'h55555, 20'hAAAAA);
      send_reading(20'hAAAAA, 20'h55555);
      drain();

      // All-ones and extreme coefficients
      write_reg(CSR_TEMP_CAL, '1);
      write_reg(CSR_PRESS_LOW, '1);
      write_reg(CSR_PRESS_HIGH, '1);
      write_reg(CSR_PRESS_NINE, '1);
      send_reading('0, '0);
      send_reading(20'hFFFFF, 20'hFFFFF);
      send_reading(20'h12345, 20'h80000);
      drain();
      write_reg(CSR_TEMP_CAL, 48'h8000_7FFF_FFFF);
      write_reg(CSR_PRESS_LOW, 64'h7FFF_8000_7FFF_FFFF);
      write_reg(CSR_PRESS_HIGH, 64'h8000_7FFF_8000_7FFF);
      write_reg(CSR_PRESS_NINE, 64'h8000);
      send_reading('0, '0);
      send_reading(20'hFFFFF, 20'hFFFFF);
      send_reading(20'h80000, 20'h7FFFF);
      drain();

      // Random phases: mostly plausible calibration and readings
      load_typical();
      calm = 1;
      random_burst(200, 1);
      calm = 0;
      random_burst(300, 1);
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         load_random();
         random_burst(100, 0);
         drain();
      end
      load_typical();
      random_burst(130, 1);
      drain();

      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
